FILE: rtl/cne_pkg.sv
// ----------------------------------------------------------------------------
// cne_pkg
// Shared types, codes and helper functions of the UID enumeration master.
// ----------------------------------------------------------------------------
package cne_pkg;

    localparam int SLOT_COUNT_DEF     = 4;
    localparam int REQUIRED_NODES_DEF = 3;
    localparam int UID_BYTES          = 12;
    localparam int UID_W              = 8 * UID_BYTES;

    localparam logic [31:0] FNV_BASIS     = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME     = 32'h0100_0193;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [7:0]  ACK_MARK      = 8'hA5;
    localparam logic [3:0]  FULL_MASK     = 4'h F;
    localparam logic [1:0]  ATTEMPT_LIMIT = 2'd3;
    localparam logic [3:0]  FRAME_LEN     = 4'd8;

    // request command codes
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_FRAME   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_INIT    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_COLLECT  = 3'd1,
        PH_ASSIGN   = 3'd2,
        PH_WAIT_ACK = 3'd3,
        PH_RETRY    = 3'd4,
        PH_READY    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_INVALID   = 3'd1,
        EV_OVERFLOW  = 3'd2,
        EV_TIMEOUT   = 3'd3,
        EV_STARTFAIL = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        CFG_ANNOUNCE_ID = 3'd0,
        CFG_ACK_ID      = 3'd1,
        CFG_START_ID    = 3'd2,
        CFG_ASSIGN_ID   = 3'd3,
        CFG_COLLECT_MS  = 3'd4,
        CFG_RESTART_MS  = 3'd5,
        CFG_ACK_TO_MS   = 3'd6,
        CFG_RETRY_MS    = 3'd7
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic hash;
        logic check;
        logic sort;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_hash;
        logic hash_last;
        logic need_sort;
        logic sort_last;
    } t_dp_stat;

    // due time reached: signed wrap-around difference not negative
    function automatic logic reached(input logic [31:0] now, input logic [31:0] due);
        logic [31:0] diff;
        diff = now - due;
        return ~diff[31];
    endfunction

    // CRC-16-CCITT, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        end
        return x;
    endfunction

    // byte 0 of the UID becomes the most significant byte of the sort key
    function automatic logic [UID_W-1:0] uid_key(input logic [UID_W-1:0] uid);
        logic [UID_W-1:0] key;
        for (int k = 0; k < UID_BYTES; k++) begin
            key[8*(UID_BYTES-1-k) +: 8] = uid[8*k +: 8];
        end
        return key;
    endfunction

endpackage

FILE: rtl/cne_ctrl.sv
// ----------------------------------------------------------------------------
// cne_ctrl
// Sequencer: load, execute, UID hash loop, check, sort passes, result strobe.
// ----------------------------------------------------------------------------
module cne_ctrl import cne_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_result_valid
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_HASH  = 6'b000100,
        ST_CHECK = 6'b001000,
        ST_SORT  = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_EXEC;
            ST_EXEC:  n_state = i_stat.need_hash ? ST_HASH : ST_EMIT;
            ST_HASH:  if (i_stat.hash_last) n_state = ST_CHECK;
            ST_CHECK: n_state = i_stat.need_sort ? ST_SORT : ST_EMIT;
            ST_SORT:  if (i_stat.sort_last) n_state = ST_EMIT;
            ST_EMIT:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    always_comb begin
        o_cmd.load  = (r_state == ST_IDLE) && i_start;
        o_cmd.exec  = (r_state == ST_EXEC);
        o_cmd.hash  = (r_state == ST_HASH);
        o_cmd.check = (r_state == ST_CHECK);
        o_cmd.sort  = (r_state == ST_SORT);
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = (r_state == ST_EMIT);

    // strobe is a single cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_result_valid))
        else $error("request accepted but not busy");

    // hash loop hands over to the check step
    a_hash_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HASH && i_stat.hash_last) |=> (r_state == ST_CHECK))
        else $error("hash loop exit lost");

endmodule

FILE: rtl/cne_dp.sv
// ----------------------------------------------------------------------------
// cne_dp
// Datapath: protocol state, node slots, FNV/CRC byte unit, odd-even sorter.
// ----------------------------------------------------------------------------
module cne_dp import cne_pkg::*; #(
    parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
    parameter int REQUIRED_NODES = REQUIRED_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [1:0]  i_req_cmd,
    input  logic [31:0] i_now_ms,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_frame_len,
    input  logic [63:0] i_frame_payload,
    input  logic        i_tx_accepted,
    output logic        o_tx_valid,
    output logic        o_tx_is_assign,
    output logic [63:0] o_tx_payload,
    output logic        o_frame_consumed,
    output logic [2:0]  o_phase,
    output logic [2:0]  o_event_res,
    output logic [3:0]  o_active_nodes
);

    localparam int IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW  = $clog2(SLOT_COUNT + 1);
    localparam int LIM = (REQUIRED_NODES < SLOT_COUNT) ? REQUIRED_NODES : SLOT_COUNT;

    // configuration
    logic [10:0] r_ann_id, r_ack_id;
    logic [15:0] r_collect_ms, r_restart_ms, r_ack_to_ms, r_retry_ms;

    // latched request
    t_cmd        r_cmd;
    logic [31:0] r_now;
    logic [10:0] r_fid;
    logic [3:0]  r_flen;
    logic [63:0] r_pay;
    logic        r_txok;

    // protocol state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_session, n_session;
    logic [CW-1:0] r_ccount, n_ccount;
    logic [2:0]  r_apos, n_apos;
    logic [1:0]  r_att, n_att;
    logic [31:0] r_dl_time, n_dl_time, r_rs_time, n_rs_time, r_sr_time, n_sr_time;
    logic        r_dl_arm, n_dl_arm, r_rs_arm, n_rs_arm, r_sr_arm, n_sr_arm;
    logic        r_ever, n_ever;

    // slots
    logic [23:0]      r_tok  [SLOT_COUNT];
    logic [23:0]      n_tok  [SLOT_COUNT];
    logic [UID_W-1:0] r_uid  [SLOT_COUNT];
    logic [UID_W-1:0] n_uid  [SLOT_COUNT];
    logic [3:0]       r_frag [SLOT_COUNT];
    logic [3:0]       n_frag [SLOT_COUNT];
    logic [15:0]      r_crc  [SLOT_COUNT];
    logic [15:0]      n_crc  [SLOT_COUNT];
    logic [2:0]       r_num  [SLOT_COUNT];
    logic [2:0]       n_num  [SLOT_COUNT];

    // hash / sort units
    logic [31:0]   r_hash, n_hash;
    logic [15:0]   r_crcacc, n_crcacc;
    logic [3:0]    r_bcnt, n_bcnt;
    logic [IW-1:0] r_idx, n_idx;
    logic [2:0]    r_pass, n_pass;

    // result
    logic        r_txv, n_txv, r_txa, n_txa, r_cons, n_cons;
    logic [63:0] r_txd, n_txd;
    t_event      r_ev, n_ev;

    // step helpers
    logic          f_round, f_send_start, f_assign, f_sched, f_later;
    logic          w_need_hash, w_need_sort;
    logic          w_found, w_all_full, w_ack_ok, w_ann_ok;
    logic [IW-1:0] w_fidx, w_idx, w_apos;
    logic [23:0]   w_tok;
    logic [1:0]    w_frag;
    logic [3:0]    w_newfrag;
    logic [7:0]    w_byte;

    assign w_apos = r_apos[IW-1:0];
    assign w_tok  = r_pay[63:40];
    assign w_frag = r_pay[9:8];
    assign w_byte = r_uid[r_idx][{r_bcnt, 3'b000} +: 8];

    // token lookup over the collected slots, lowest index wins
    always_comb begin
        w_found = 1'b0;
        w_fidx  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (i < int'(r_ccount) && r_tok[i] == w_tok) begin
                w_found = 1'b1;
                w_fidx  = IW'(i);
            end
        end
        w_idx     = w_found ? w_fidx : r_ccount[IW-1:0];
        w_newfrag = (w_found ? r_frag[w_fidx] : 4'd0) | (4'd1 << w_frag);
    end

    always_comb begin
        w_all_full = 1'b1;
        for (int i = 0; i < LIM; i++) begin
            if (r_frag[i] != FULL_MASK) w_all_full = 1'b0;
        end
    end

    // frame checks
    assign w_ack_ok = (r_flen == FRAME_LEN) && (r_phase == PH_WAIT_ACK)
                   && (r_pay[7:0] == r_session) && (r_pay[63:56] == ACK_MARK)
                   && (r_pay[15:8] == {5'd0, r_num[w_apos]})
                   && (r_pay[39:16] == r_tok[w_apos])
                   && (r_pay[55:40] == r_crc[w_apos]);
    assign w_ann_ok = (r_flen == FRAME_LEN) && (r_phase == PH_COLLECT) && !r_rs_arm
                   && (r_pay[7:0] == r_session) && (r_pay[15:10] == 6'd0);

    // step logic
    always_comb begin
        n_phase = r_phase;   n_session = r_session; n_ccount = r_ccount;
        n_apos  = r_apos;    n_att     = r_att;     n_ever   = r_ever;
        n_dl_time = r_dl_time; n_rs_time = r_rs_time; n_sr_time = r_sr_time;
        n_dl_arm  = r_dl_arm;  n_rs_arm  = r_rs_arm;  n_sr_arm  = r_sr_arm;
        n_tok = r_tok; n_uid = r_uid; n_frag = r_frag; n_crc = r_crc; n_num = r_num;
        n_hash = r_hash; n_crcacc = r_crcacc; n_bcnt = r_bcnt; n_idx = r_idx;
        n_pass = r_pass;
        n_txv = r_txv; n_txa = r_txa; n_txd = r_txd; n_cons = r_cons; n_ev = r_ev;
        f_round = 1'b0; f_send_start = 1'b0; f_assign = 1'b0;
        f_sched = 1'b0; f_later = 1'b0;
        w_need_hash = 1'b0; w_need_sort = 1'b0;

        if (i_cmd.exec) begin
            n_txv = 1'b0; n_txa = 1'b0; n_txd = '0; n_cons = 1'b0; n_ev = EV_NONE;
            case (r_cmd)
                CMD_TICK: begin
                    if (r_sr_arm && reached(r_now, r_sr_time)) begin
                        n_sr_arm = 1'b0;
                        f_send_start = 1'b1;
                    end else if (r_rs_arm && reached(r_now, r_rs_time)) begin
                        n_rs_arm = 1'b0;
                        f_round = 1'b1;
                    end else if (r_phase == PH_COLLECT && r_dl_arm
                                 && reached(r_now, r_dl_time)) begin
                        n_ev = EV_TIMEOUT;
                        f_later = 1'b1;
                    end else if (r_phase == PH_RETRY && reached(r_now, r_dl_time)) begin
                        n_phase = PH_ASSIGN;
                    end else if (r_phase == PH_ASSIGN) begin
                        f_assign = 1'b1;
                    end else if (r_phase == PH_WAIT_ACK && reached(r_now, r_dl_time)) begin
                        f_sched = 1'b1;
                    end
                end
                CMD_FRAME: begin
                    if (r_fid == r_ack_id) begin
                        n_cons = 1'b1;
                        if (!w_ack_ok) begin
                            n_ev = EV_INVALID;
                        end else begin
                            n_apos = r_apos + 3'd1;
                            n_att  = 2'd0;
                            if (int'(n_apos) >= REQUIRED_NODES) begin
                                n_phase = PH_READY;
                                n_ever  = 1'b1;
                            end else begin
                                n_phase = PH_ASSIGN;
                            end
                        end
                    end else if (r_fid == r_ann_id) begin
                        n_cons = 1'b1;
                        if (!w_ann_ok) begin
                            n_ev = EV_INVALID;
                        end else if (!w_found && int'(r_ccount) >= SLOT_COUNT) begin
                            n_ev = EV_OVERFLOW;
                            f_later = 1'b1;
                        end else begin
                            // store fragment, start UID check when complete
                            n_tok[w_idx]  = w_tok;
                            n_uid[w_idx][7'(w_frag) * 7'd24 +: 24] = r_pay[39:16];
                            n_frag[w_idx] = w_newfrag;
                            if (!w_found) n_ccount = r_ccount + CW'(1);
                            n_idx    = w_idx;
                            n_hash   = FNV_BASIS;
                            n_crcacc = CRC_INIT;
                            n_bcnt   = 4'd0;
                            w_need_hash = (w_newfrag == FULL_MASK);
                        end
                    end
                end
                CMD_RESTART: begin
                    n_rs_arm = 1'b0;
                    n_sr_arm = 1'b0;
                    f_round  = 1'b1;
                end
                CMD_INIT: begin
                    n_phase = PH_IDLE; n_session = 8'd0; n_ccount = '0;
                    n_apos = 3'd0; n_att = 2'd0; n_ever = 1'b0;
                    f_round = 1'b1;
                end
                default: ;
            endcase
        end else if (i_cmd.hash) begin
            // one UID byte per cycle through FNV-1a and CRC
            n_hash   = (r_hash ^ {24'd0, w_byte}) * FNV_PRIME;
            n_crcacc = crc_byte(r_crcacc, w_byte);
            n_bcnt   = r_bcnt + 4'd1;
        end else if (i_cmd.check) begin
            n_crc[r_idx] = r_crcacc;
            if (r_hash[23:0] != r_tok[r_idx]) begin
                n_ev = EV_INVALID;
                f_later = 1'b1;
            end else if (int'(r_ccount) == REQUIRED_NODES && w_all_full) begin
                n_apos  = 3'd0;
                n_att   = 2'd0;
                n_phase = PH_ASSIGN;
                n_pass  = 3'd0;
                w_need_sort = 1'b1;
            end
        end else if (i_cmd.sort) begin
            // odd-even transposition pass over fixed neighbor pairs
            for (int k = 0; k < LIM - 1; k++) begin
                if ((k % 2) == int'(r_pass[0])
                    && uid_key(r_uid[k]) > uid_key(r_uid[k+1])) begin
                    n_tok[k]  = r_tok[k+1];  n_tok[k+1]  = r_tok[k];
                    n_uid[k]  = r_uid[k+1];  n_uid[k+1]  = r_uid[k];
                    n_frag[k] = r_frag[k+1]; n_frag[k+1] = r_frag[k];
                    n_crc[k]  = r_crc[k+1];  n_crc[k+1]  = r_crc[k];
                end
            end
            if (r_pass == 3'(LIM - 1)) begin
                for (int k = 0; k < LIM; k++) n_num[k] = 3'(k + 1);
            end
            n_pass = r_pass + 3'd1;
        end

        // new round
        if (f_round) begin
            n_session = n_session + 8'd1;
            if (n_session == 8'd0) n_session = 8'd1;
            for (int i = 0; i < SLOT_COUNT; i++) n_frag[i] = 4'd0;
            n_ccount = '0; n_apos = 3'd0; n_att = 2'd0;
            n_sr_arm = 1'b0;
            f_send_start = 1'b1;
        end
        // start broadcast
        if (f_send_start) begin
            n_txv = 1'b1; n_txa = 1'b0; n_txd = {56'd0, n_session};
            n_phase = PH_COLLECT;
            if (r_txok) begin
                n_dl_time = r_now + {16'd0, r_collect_ms};
                n_dl_arm  = 1'b1;
            end else begin
                n_ev = EV_STARTFAIL;
                n_dl_arm  = 1'b0;
                n_sr_time = r_now + {16'd0, r_retry_ms};
                n_sr_arm  = 1'b1;
            end
        end
        // assign frame for the current position
        if (f_assign) begin
            n_txv = 1'b1; n_txa = 1'b1;
            n_txd = {8'd0, r_crc[w_apos], r_tok[w_apos], 5'd0, r_num[w_apos], r_session};
            if (r_txok) begin
                n_phase   = PH_WAIT_ACK;
                n_dl_time = r_now + {16'd0, r_ack_to_ms};
                n_dl_arm  = 1'b1;
            end else begin
                f_sched = 1'b1;
            end
        end
        // retry or give up
        if (f_sched) begin
            n_att = r_att + 2'd1;
            if (n_att >= ATTEMPT_LIMIT) begin
                n_ev = EV_TIMEOUT;
                f_later = 1'b1;
            end else begin
                n_phase   = PH_RETRY;
                n_dl_time = r_now + {16'd0, r_retry_ms};
                n_dl_arm  = 1'b1;
            end
        end
        // delayed restart
        if (f_later) begin
            n_phase   = PH_COLLECT;
            n_rs_time = r_now + {16'd0, r_restart_ms};
            n_rs_arm  = 1'b1;
            n_sr_arm  = 1'b0;
            n_dl_arm  = 1'b0;
        end
    end

    // request latch and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= t_cmd'(i_req_cmd);
            r_now  <= i_now_ms;
            r_fid  <= i_frame_id;
            r_flen <= i_frame_len;
            r_pay  <= i_frame_payload;
            r_txok <= i_tx_accepted;
        end
        r_tok <= n_tok; r_uid <= n_uid; r_crc <= n_crc; r_num <= n_num;
        r_hash <= n_hash; r_crcacc <= n_crcacc; r_bcnt <= n_bcnt; r_idx <= n_idx;
        r_pass <= n_pass;
        r_txv <= n_txv; r_txa <= n_txa; r_txd <= n_txd; r_cons <= n_cons; r_ev <= n_ev;
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_session <= 8'd0; r_ccount <= '0;
            r_apos <= 3'd0; r_att <= 2'd0; r_ever <= 1'b0;
            r_dl_time <= '0; r_rs_time <= '0; r_sr_time <= '0;
            r_dl_arm <= 1'b0; r_rs_arm <= 1'b0; r_sr_arm <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) r_frag[i] <= 4'd0;
            r_ann_id <= 11'd0; r_ack_id <= 11'd0;
            r_collect_ms <= 16'd4500; r_restart_ms <= 16'd300;
            r_ack_to_ms <= 16'd100; r_retry_ms <= 16'd20;
        end else begin
            r_phase <= n_phase; r_session <= n_session; r_ccount <= n_ccount;
            r_apos <= n_apos; r_att <= n_att; r_ever <= n_ever;
            r_dl_time <= n_dl_time; r_rs_time <= n_rs_time; r_sr_time <= n_sr_time;
            r_dl_arm <= n_dl_arm; r_rs_arm <= n_rs_arm; r_sr_arm <= n_sr_arm;
            r_frag <= n_frag;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ANNOUNCE_ID: r_ann_id     <= i_cfg_data[10:0];
                    CFG_ACK_ID:      r_ack_id     <= i_cfg_data[10:0];
                    CFG_COLLECT_MS:  r_collect_ms <= i_cfg_data;
                    CFG_RESTART_MS:  r_restart_ms <= i_cfg_data;
                    CFG_ACK_TO_MS:   r_ack_to_ms  <= i_cfg_data;
                    CFG_RETRY_MS:    r_retry_ms   <= i_cfg_data;
                    default: ;   // frame labels only, nothing stored
                endcase
            end
        end
    end

    // status
    always_comb begin
        o_stat.need_hash = w_need_hash;
        o_stat.hash_last = (r_bcnt == 4'(UID_BYTES - 1));
        o_stat.need_sort = w_need_sort;
        o_stat.sort_last = (r_pass == 3'(LIM - 1));
    end

    assign o_tx_valid       = r_txv;
    assign o_tx_is_assign   = r_txa;
    assign o_tx_payload     = r_txd;
    assign o_frame_consumed = r_cons;
    assign o_phase          = r_phase;
    assign o_event_res      = r_ev;
    assign o_active_nodes   = r_ever ? 4'(REQUIRED_NODES) : 4'd0;

    // collected count never exceeds the slot array
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ccount) <= SLOT_COUNT)
        else $error("slot count overrun");

    // readiness always reports the assigned node count
    a_ready_nodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_READY) |-> r_ever)
        else $error("ready without completed round");

    // a pending start retry disarms the collect deadline
    a_sr_dl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sr_arm && r_phase == PH_COLLECT) |-> !r_dl_arm)
        else $error("start retry with deadline armed");

endmodule

FILE: rtl/can_node_uid_enumerator.sv
// ----------------------------------------------------------------------------
// can_node_uid_enumerator
// Bus master that enumerates nodes by UID and assigns node IDs.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------
//  request  | i_start / o_busy               | i_cmd, i_now_ms, i_frame_*,
//           |                                | i_tx_accepted
//  result   | o_result_valid (1-cycle strobe)| o_tx_*, o_frame_consumed,
//           |                                | o_phase, o_event_res, ...
//  config   | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// A request is latched, executed and then answered by the result strobe. An
// announce completing a UID adds a byte-serial FNV/CRC loop (12 bytes), a
// check, and for the full node set min(REQUIRED_NODES, SLOT_COUNT) sort passes.
// Reset is synchronous, active low; no clearing pass is needed.
// Register writes are held off while a request is in flight.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module can_node_uid_enumerator import cne_pkg::*; #(
    parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
    parameter int REQUIRED_NODES = REQUIRED_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_frame_len,
    input  logic [63:0] i_frame_payload,
    input  logic        i_tx_accepted,
    output logic        o_result_valid,
    output logic        o_tx_valid,
    output logic        o_tx_is_assign,
    output logic [63:0] o_tx_payload,
    output logic        o_frame_consumed,
    output logic [2:0]  o_phase,
    output logic [2:0]  o_event_res,
    output logic [3:0]  o_active_nodes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // registers only change between requests
    assign o_cfg_ready = ~o_busy;

    cne_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid)
    );

    cne_dp #(
        .SLOT_COUNT     (SLOT_COUNT),
        .REQUIRED_NODES (REQUIRED_NODES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_req_cmd        (i_cmd),
        .i_now_ms         (i_now_ms),
        .i_frame_id       (i_frame_id),
        .i_frame_len      (i_frame_len),
        .i_frame_payload  (i_frame_payload),
        .i_tx_accepted    (i_tx_accepted),
        .o_tx_valid       (o_tx_valid),
        .o_tx_is_assign   (o_tx_is_assign),
        .o_tx_payload     (o_tx_payload),
        .o_frame_consumed (o_frame_consumed),
        .o_phase          (o_phase),
        .o_event_res      (o_event_res),
        .o_active_nodes   (o_active_nodes)
    );

endmodule
